>>> sv/md5wm_pkg.sv
// ----------------------------------------------------------------------------
// md5wm_pkg
// shared constants and helper functions of the md5 block watermark unit
// ----------------------------------------------------------------------------
`default_nettype none
package md5wm_pkg;

	localparam int BLK_PIXELS = 64;
	localparam int HASHED_BITS_DEF = 5;
	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;
	localparam logic [1:0] REG_MODE = 2'd0;

	function automatic logic [31:0] sine_k(input logic [5:0] i);
		logic [31:0] k;
		begin
			case (i)
				6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756;
				6'd2: k = 32'h242070db; 6'd3: k = 32'hc1bdceee;
				6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
				6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501;
				6'd8: k = 32'h698098d8; 6'd9: k = 32'h8b44f7af;
				6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
				6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
				6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
				6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
				6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
				6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
				6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
				6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
				6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
				6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
				6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
				6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
				6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
				6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
				6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
				6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
				6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
				6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
				6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
				6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
				6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
				6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
				6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
				6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
				6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
				6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
				6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
			endcase
			return k;
		end
	endfunction

	function automatic logic [4:0] rot_s(input logic [5:0] i);
		logic [4:0] s;
		begin
			case ({i[5:4], i[1:0]})
				4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
				4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
				4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
				4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
			endcase
			return s;
		end
	endfunction

	// message word index used by round i
	function automatic logic [3:0] word_g(input logic [5:0] i);
		logic [3:0] g;
		begin
			case (i[5:4])
				2'd0: g = i[3:0];
				2'd1: g = 4'(5 * i[3:0] + 1);
				2'd2: g = 4'(3 * i[3:0] + 5);
				default: g = 4'(7 * i[3:0]);
			endcase
			return g;
		end
	endfunction

endpackage
`default_nettype wire

>>> sv/md5_block_watermark_auth.sv
// ----------------------------------------------------------------------------
// md5_block_watermark_auth
// fragile md5 watermark for one 8x8 block: embed or verify
// ----------------------------------------------------------------------------
// channel   direction  signals                                   accept
// in        input      in_valid/in_stall, pixel, ref_bit          valid & !stall
// out       output     out_valid/out_stall, out_pixel, auth_bit,  valid & !stall
//                      block_ok, last
// cfg       input      apb psel/penable/pwrite/paddr/pwdata       psel&penable&pwrite
//
// the first 63 items of a block are only stored; the 64th also starts the
// hash: each md5 round gathers its word from the pixel ram one byte a cycle
// and then applies the round, and each chunk ends with a digest add; an lsb
// sweep then checks the block, and the 64 results leave one at a time, each
// after its own ram read. reset clears control state only; the rams need
// no clearing. a stalled output holds its item; input is not taken while
// hashing or emitting.
// ----------------------------------------------------------------------------
`default_nettype none
module md5_block_watermark_auth #(
	parameter int HASHED_BITS = md5wm_pkg::HASHED_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  pixel,
	input  wire logic        ref_bit,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [7:0]  out_pixel,
	output logic             auth_bit,
	output logic             block_ok,
	output logic             last,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	localparam int MSG_BYTES = 64 * HASHED_BITS;
	localparam int NCHUNK = (MSG_BYTES + 8) / 64 + 1;
	localparam int TOT_BYTES = NCHUNK * 64;
	localparam int BW = $clog2(TOT_BYTES + 1);
	localparam logic [63:0] MSG_BITS = 64'(MSG_BYTES * 8);
	localparam int DIV_SH = BW + 3;
	localparam logic [DIV_SH:0] DIV_M =
		(DIV_SH + 1)'(((1 << DIV_SH) + HASHED_BITS - 1) / HASHED_BITS);

	localparam logic [2:0] ST_FILL = 3'd0;
	localparam logic [2:0] ST_BYTE = 3'd1; // byte fetch for current round word
	localparam logic [2:0] ST_RND  = 3'd2; // apply round
	localparam logic [2:0] ST_FIN  = 3'd3; // chunk add
	localparam logic [2:0] ST_CHK  = 3'd4; // lsb check sweep
	localparam logic [2:0] ST_EMIT = 3'd5;

	logic [2:0]  state_q;
	logic [5:0]  cnt_q;       // fill count / sweep index
	logic        mode_q;
	logic [31:0] a_q, b_q, c_q, d_q, h0_q, h1_q, h2_q, h3_q;
	logic [5:0]  rnd_q;
	logic [BW-1:0] chunk_base_q;
	logic [2:0]  bcnt_q;      // byte phase 0..4 (4 = last byte arriving)
	logic [31:0] w_q;
	logic [BW-1:0] pend_idx_q; // byte index whose ram read is in flight
	logic        ok_q;
	logic        chk_rd_q;
	logic        ov_q;
	logic [7:0]  op_q;
	logic        ab_q, bo_q, la_q;
	logic        emit_rd_q;
	logic [5:0]  emit_p_q;

	// ram ports
	logic       we;
	logic [5:0] raddr;
	logic [7:0] pix_rd;
	logic       ref_rd;

	md5wm_ram #(.WIDTH(8), .DEPTH(md5wm_pkg::BLK_PIXELS)) u_pix (
		.clk(clk), .we(we), .waddr(cnt_q), .wdata(pixel), .raddr(raddr), .rdata(pix_rd));
	md5wm_ram #(.WIDTH(1), .DEPTH(md5wm_pkg::BLK_PIXELS)) u_ref (
		.clk(clk), .we(we), .waddr(cnt_q), .wdata(ref_bit), .raddr(raddr), .rdata(ref_rd));

	assign in_stall = (state_q != ST_FILL);
	assign we = in_valid && (state_q == ST_FILL);
	assign pready = 1'b1;
	assign prdata = {31'd0, mode_q};

	// digest bit for pixel p: c = col*8+row, bit (7-c%8) of digest byte c/8
	function automatic logic hbit(input logic [5:0] p, input logic [31:0] w0,
			input logic [31:0] w1);
		logic [5:0] c;
		logic [63:0] dg;
		begin
			c = {p[2:0], p[5:3]};
			dg = {w1, w0};
			return dg[{c[5:3], 3'b111 - c[2:0]}];
		end
	endfunction

	// x / HASHED_BITS by reciprocal multiply, exact for any x below 2**BW
	function automatic logic [BW-1:0] div_h(input logic [BW-1:0] x);
		logic [BW+DIV_SH:0] prod;
		begin
			prod = {{(DIV_SH + 1){1'b0}}, x} * {{BW{1'b0}}, DIV_M};
			return prod[DIV_SH +: BW];
		end
	endfunction

	// byte index of the round word being built
	logic [5:0]  g;
	logic [BW-1:0] bidx;
	logic [BW-1:0] bpix;      // pixel holding the byte being read
	logic [BW-1:0] pix_num;
	logic [BW-1:0] krem;
	logic [2:0]  kbit;
	logic [BW-1:0] tail;
	logic [7:0]  byte_val;
	assign g = {2'b00, md5wm_pkg::word_g(rnd_q)};
	assign bidx = chunk_base_q + BW'({g[3:0], bcnt_q[1:0]});
	assign bpix = div_h(bidx);
	assign pix_num = div_h(pend_idx_q);
	assign krem = pend_idx_q - BW'(pix_num * HASHED_BITS);
	assign kbit = krem[2:0];
	assign tail = pend_idx_q - BW'(MSG_BYTES);

	always_comb begin
		raddr = 6'd0;
		if (state_q == ST_BYTE) raddr = bpix[5:0];
		else if (state_q == ST_CHK || state_q == ST_EMIT) raddr = cnt_q;
		if (pend_idx_q < BW'(MSG_BYTES)) byte_val = 8'h30 | {7'd0, pix_rd[3'd7 - kbit]};
		else if (tail == '0) byte_val = 8'h80;
		else if (tail >= BW'(56)) byte_val = MSG_BITS[{tail[2:0], 3'b000} +: 8];
		else byte_val = 8'h00;
	end

	// md5 round
	logic [31:0] f, t, rot;
	logic [4:0]  sh;
	always_comb begin
		case (rnd_q[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (d_q & b_q) | (~d_q & c_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		t = f + a_q + md5wm_pkg::sine_k(rnd_q) + w_q;
		sh = md5wm_pkg::rot_s(rnd_q);
		rot = (t << sh) | (t >> (6'd32 - {1'b0, sh}));
	end

	logic out_free;
	logic emit_fire;
	logic chk_bad;
	assign out_free = !ov_q || !out_stall;
	assign emit_fire = (state_q == ST_EMIT) && emit_rd_q && out_free;
	assign chk_bad = chk_rd_q && (pix_rd[0] != hbit(emit_p_q, h0_q, h1_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL; cnt_q <= '0; mode_q <= 1'b0;
			h0_q <= md5wm_pkg::IV_A; h1_q <= md5wm_pkg::IV_B;
			h2_q <= md5wm_pkg::IV_C; h3_q <= md5wm_pkg::IV_D;
			rnd_q <= '0; chunk_base_q <= '0; bcnt_q <= '0; ok_q <= 1'b0;
			chk_rd_q <= 1'b0; ov_q <= 1'b0; emit_rd_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr == md5wm_pkg::REG_MODE)
				mode_q <= pwdata[0];
			if (emit_fire) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
			unique case (state_q)
				ST_FILL: if (we) begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						state_q <= ST_BYTE; bcnt_q <= '0; rnd_q <= '0; chunk_base_q <= '0;
						h0_q <= md5wm_pkg::IV_A; h1_q <= md5wm_pkg::IV_B;
						h2_q <= md5wm_pkg::IV_C; h3_q <= md5wm_pkg::IV_D;
						a_q <= md5wm_pkg::IV_A; b_q <= md5wm_pkg::IV_B;
						c_q <= md5wm_pkg::IV_C; d_q <= md5wm_pkg::IV_D;
					end
				end
				ST_BYTE: begin
					// read issued for byte bcnt, byte bcnt-1 arrives
					if (bcnt_q != 3'd0) w_q <= {byte_val, w_q[31:8]};
					pend_idx_q <= bidx;
					if (bcnt_q == 3'd4) begin
						state_q <= ST_RND;
						bcnt_q <= '0;
					end else bcnt_q <= bcnt_q + 3'd1;
				end
				ST_RND: begin
					a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_q + rot;
					rnd_q <= rnd_q + 6'd1;
					state_q <= (rnd_q == 6'd63) ? ST_FIN : ST_BYTE;
				end
				ST_FIN: begin
					h0_q <= h0_q + a_q; h1_q <= h1_q + b_q;
					h2_q <= h2_q + c_q; h3_q <= h3_q + d_q;
					a_q <= h0_q + a_q; b_q <= h1_q + b_q;
					c_q <= h2_q + c_q; d_q <= h3_q + d_q;
					if (chunk_base_q == BW'(TOT_BYTES - 64)) begin
						state_q <= ST_CHK; cnt_q <= '0; ok_q <= 1'b1; chk_rd_q <= 1'b0;
					end else begin
						chunk_base_q <= chunk_base_q + BW'(64);
						state_q <= ST_BYTE;
					end
				end
				ST_CHK: begin
					chk_rd_q <= 1'b1;
					emit_p_q <= cnt_q;
					if (chk_bad) ok_q <= 1'b0;
					if (chk_rd_q && emit_p_q == 6'd63) begin
						state_q <= ST_EMIT; cnt_q <= '0; emit_rd_q <= 1'b0;
					end else cnt_q <= cnt_q + 6'd1;
				end
				ST_EMIT: begin
					// ram read in flight for emit_p_q when emit_rd_q
					if (emit_fire) begin
						ab_q <= hbit(emit_p_q, h0_q, h1_q);
						la_q <= (emit_p_q == 6'd63);
						bo_q <= mode_q & ok_q;
						if (mode_q) op_q <= ok_q ? 8'hFF : 8'h00;
						else op_q <= (pix_rd & 8'hFC) + {7'd0, hbit(emit_p_q, h0_q, h1_q)}
							+ {6'd0, ref_rd, 1'b0};
						emit_rd_q <= 1'b0;
						if (emit_p_q == 6'd63) begin
							state_q <= ST_FILL; cnt_q <= '0;
						end else cnt_q <= emit_p_q + 6'd1;
					end else if (!emit_rd_q) begin
						emit_rd_q <= 1'b1; emit_p_q <= cnt_q;
					end
				end
				default: state_q <= ST_FILL;
			endcase
		end
	end

	assign out_valid = ov_q;
	assign out_pixel = op_q;
	assign auth_bit = ab_q;
	assign block_ok = bo_q;
	assign last = la_q;

	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_FILL) |-> !we) else $error("item taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_stall) |=> (ov_q && $stable(op_q))) else $error("output lost");
	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> ($past(state_q) == ST_EMIT)) else $error("stray result");
	a_embed_ok0: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && bo_q) |-> (op_q == 8'hFF)) else $error("ok mismatch");
endmodule
`default_nettype wire

>>> sv/md5wm_ram.sv
// ----------------------------------------------------------------------------
// md5wm_ram
// generic single-port-write, single-read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module md5wm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> verif/tb_md5_block_watermark_auth.sv
// ----------------------------------------------------------------------------
// tb_md5_block_watermark_auth
// self-checking bench for the md5 block watermark unit: blocks of 64 pixels
// go in through a gapped valid/stall driver, an md5 predictor builds the
// 64 expected results per block, and a monitor checks them in order while
// the output side stalls at random. mode is switched over apb between
// phases, once in the middle of a block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_md5_block_watermark_auth;

	typedef logic [7:0] blk_t [64];

	typedef struct packed {
		logic [7:0] pixel;
		logic       ref_bit;
	} pix_item_t;

	typedef struct packed {
		logic [7:0] out_pixel;
		logic       auth_bit;
		logic       block_ok;
		logic       last;
	} wm_result_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 2500;
	// md5 shift amounts, entry n at bits [5n +: 5], n = {round group, i[1:0]}
	localparam logic [79:0] SHIFT_TAB = {5'd21, 5'd15, 5'd10, 5'd6, 5'd23, 5'd16,
		5'd11, 5'd4, 5'd20, 5'd14, 5'd9, 5'd5, 5'd22, 5'd17, 5'd12, 5'd7};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  pixel = '0;
	logic        ref_bit = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_pixel;
	logic        auth_bit;
	logic        block_ok;
	logic        last;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	md5_block_watermark_auth DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .pixel(pixel), .ref_bit(ref_bit),
		.out_valid(out_valid), .out_stall(out_stall), .out_pixel(out_pixel),
		.auth_bit(auth_bit), .block_ok(block_ok), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #4 clk = ~clk;

	// bench state
	pix_item_t   pending_pixels [$];
	wm_result_t  expected_results [$];
	logic [31:0] sine_k [64];
	blk_t        blk_pixels;
	logic        blk_refs [64];
	int          fill_count = 0;
	logic        mode_copy = 1'b0;
	int          err_count = 0;
	int          idle_cycles = 0;
	logic        in_took = 1'b0;
	int          in_gap = 0;
	int          stall_left = 0;
	int          hold_left = 0;
	logic        hold_request = 1'b0;
	logic        calm = 1'b0;

	// md5 round constants, floor(|sin(i+1)| * 2^32)
	initial begin
		for (int i = 0; i < 64; i++)
			sine_k[i] = 32'(longint'($floor(((($sin(i + 1.0)) < 0.0) ?
				-$sin(i + 1.0) : $sin(i + 1.0)) * 4294967296.0)));
	end

	// byte idx of the padded message built from the upper pixel bits
	function automatic logic [7:0] msg_byte(input blk_t px, input int idx);
		int rel;
		begin
			if (idx < 320)
				return 8'h30 + 8'(px[idx / 5][7 - (idx % 5)]);
			rel = idx - 320;
			if (rel == 0)
				return 8'h80;
			if (rel >= 56)
				return 8'((64'd2560 >> ((rel - 56) * 8)) & 64'hff);
			return 8'h00;
		end
	endfunction

	// hash bit of every pixel position, index = row-major pixel number
	function automatic logic [63:0] block_auth_bits(input blk_t px);
		logic [31:0] dg [4];
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, f, t, word;
		logic [7:0]  byt;
		logic [63:0] bits;
		int          g, hb, bi, o;
		begin
			dg[0] = md5wm_pkg::IV_A; dg[1] = md5wm_pkg::IV_B;
			dg[2] = md5wm_pkg::IV_C; dg[3] = md5wm_pkg::IV_D;
			for (int ch = 0; ch < 6; ch++) begin
				for (int j = 0; j < 16; j++) begin
					o = ch * 64 + 4 * j;
					w[j] = {msg_byte(px, o + 3), msg_byte(px, o + 2),
						msg_byte(px, o + 1), msg_byte(px, o)};
				end
				a = dg[0]; b = dg[1]; c = dg[2]; d = dg[3];
				for (int i = 0; i < 64; i++) begin
					if (i < 16) begin
						f = (b & c) | (~b & d); g = i;
					end else if (i < 32) begin
						f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
					end else if (i < 48) begin
						f = b ^ c ^ d; g = (3 * i + 5) % 16;
					end else begin
						f = c ^ (b | ~d); g = (7 * i) % 16;
					end
					t = f + a + sine_k[i] + w[g];
					a = d; d = c; c = b;
					b = b + ((t << SHIFT_TAB[(((i >> 4) << 2) | (i & 3)) * 5 +: 5]) |
						(t >> (32 - SHIFT_TAB[(((i >> 4) << 2) | (i & 3)) * 5 +: 5])));
				end
				dg[0] += a; dg[1] += b; dg[2] += c; dg[3] += d;
			end
			for (int p = 0; p < 64; p++) begin
				// pixel at row p/8, column p%8 owns hash bit col*8+row
				hb = (p % 8) * 8 + p / 8;
				bi = hb / 8;
				word = dg[bi / 4];
				byt = word[(bi % 4) * 8 +: 8];
				bits[p] = byt[7 - (hb % 8)];
			end
			return bits;
		end
	endfunction

	// one accepted pixel: store it, and on the 64th work out the block's results
	task automatic predict_pixel(input logic [7:0] px, input logic rb);
		logic [63:0] ab;
		logic        ok;
		wm_result_t  r;
		begin
			blk_pixels[fill_count] = px;
			blk_refs[fill_count] = rb;
			fill_count++;
			if (fill_count == 64) begin
				fill_count = 0;
				ab = block_auth_bits(blk_pixels);
				ok = 1'b1;
				for (int p = 0; p < 64; p++)
					if (blk_pixels[p][0] != ab[p])
						ok = 1'b0;
				for (int p = 0; p < 64; p++) begin
					if (!mode_copy) begin
						r.out_pixel = (blk_pixels[p] & 8'hfc) + 8'(ab[p]) + 8'(2 * blk_refs[p]);
						r.block_ok = 1'b0;
					end else begin
						r.out_pixel = ok ? 8'd255 : 8'd0;
						r.block_ok = ok;
					end
					r.auth_bit = ab[p];
					r.last = (p == 63);
					expected_results.push_back(r);
				end
			end
		end
	endtask

	function automatic int pick_gap();
		int r;
		begin
			r = $urandom_range(0, 99);
			if (calm || r < 60)
				return 0;
			if (r < 92)
				return $urandom_range(1, 3);
			return $urandom_range(10, 40);
		end
	endfunction

	// driver: new item or gap at the falling edge, once the last one was taken
	always @(negedge clk) begin
		pix_item_t it;
		if (arst_n && (!in_valid || in_took)) begin
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (pending_pixels.size() > 0) begin
				it = pending_pixels.pop_front();
				in_valid <= 1'b1;
				pixel <= it.pixel;
				ref_bit <= it.ref_bit;
				in_gap <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with one long hold-off while the sender keeps offering
	always @(negedge clk) begin
		if (hold_request && out_valid) begin
			hold_request <= 1'b0;
			hold_left <= 1500;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			stall_left <= pick_gap();
		end
	end

	// monitor: accepted items feed the predictor, results are checked in order
	always @(posedge clk) begin
		wm_result_t want;
		in_took <= in_valid && !in_stall;
		if (in_valid && !in_stall)
			predict_pixel(pixel, ref_bit);
		if (out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("unexpected result: pixel %0d auth %0d ok %0d last %0d",
						out_pixel, auth_bit, block_ok, last);
			end else begin
				want = expected_results.pop_front();
				if (want != {out_pixel, auth_bit, block_ok, last}) begin
					err_count++;
					if (err_count <= 10)
						$display("mismatch pixel/auth/ok/last: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
							want.out_pixel, want.auth_bit, want.block_ok, want.last,
							out_pixel, auth_bit, block_ok, last);
				end
			end
		end
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// apb write of the mode register, setup then access
	task automatic write_mode(input logic value);
		begin
			@(negedge clk);
			psel <= 1'b1; pwrite <= 1'b1; paddr <= md5wm_pkg::REG_MODE; pwdata <= 32'(value);
			@(negedge clk);
			penable <= 1'b1;
			@(negedge clk);
			psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
			mode_copy = value;
		end
	endtask

	// wait until every item went in and every result came out, then let the
	// hash finish in case a partial block is still in flight
	task automatic drain();
		begin
			while (pending_pixels.size() > 0 || in_valid || expected_results.size() > 0)
				@(posedge clk);
			repeat (DRAIN_CYCLES) @(posedge clk);
		end
	endtask

	// queue a block; intact means the lsbs are set to the block's own hash bits
	task automatic queue_block(input blk_t px, input logic [63:0] refs, input bit intact,
			input int count);
		logic [63:0] ab;
		pix_item_t   it;
		begin
			ab = block_auth_bits(px);
			for (int p = 0; p < count; p++) begin
				it.pixel = px[p];
				if (intact)
					it.pixel[0] = ab[p];
				it.ref_bit = refs[p];
				pending_pixels.push_back(it);
			end
		end
	endtask

	initial begin
		blk_t        px;
		logic [63:0] refs;
		int          kind;
		int          flips;
		pix_item_t   it;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		write_mode(1'b0);

		// extremes in embed mode: 0, 255, and walking bits, ref alternating
		for (int p = 0; p < 64; p++) begin
			case (p % 4)
				0: px[p] = 8'h00;
				1: px[p] = 8'hff;
				2: px[p] = 8'h01 << (p % 8);
				default: px[p] = ~(8'h01 << (p % 8));
			endcase
			refs[p] = p[0];
		end
		queue_block(px, refs, 1'b0, 64);
		drain();

		// verify: intact block, then the same block with one pixel lsb flipped
		write_mode(1'b1);
		queue_block(px, refs, 1'b1, 64);
		drain();
		queue_block(px, refs, 1'b1, 64);
		it = pending_pixels[17];
		it.pixel[0] = ~it.pixel[0];
		pending_pixels[17] = it;
		drain();

		// mode switch in the middle of a block: the dut reads mode as it emits the results
		for (int p = 0; p < 64; p++) begin
			px[p] = 8'($urandom);
			refs[p] = 1'($urandom_range(0, 1));
		end
		queue_block(px, refs, 1'b1, 64);
		for (int p = 0; p < 34; p++)
			pending_pixels.pop_back();
		drain();
		write_mode(1'b0);
		for (int p = 30; p < 64; p++) begin
			it.pixel = px[p];
			it.ref_bit = refs[p];
			pending_pixels.push_back(it);
		end
		drain();

		// random blocks, mostly well formed for verify, some broken
		for (int b = 0; b < 2; b++) begin
			write_mode(1'($urandom_range(0, 1)));
			calm = (b == 0);
			for (int p = 0; p < 64; p++) begin
				px[p] = 8'($urandom);
				refs[p] = 1'($urandom_range(0, 1));
			end
			kind = $urandom_range(0, 9);
			queue_block(px, refs, kind < 7, 64);
			if (kind >= 7 && kind < 9) begin
				flips = $urandom_range(0, 63);
				it = pending_pixels[pending_pixels.size() - 64 + flips];
				it.pixel[0] = ~it.pixel[0];
				pending_pixels[pending_pixels.size() - 64 + flips] = it;
			end
			if (b == 1) begin
				// follow-up block already queued so the input backs up during the hold
				hold_request = 1'b1;
				for (int p = 0; p < 64; p++)
					px[p] = 8'($urandom);
				queue_block(px, refs, 1'b1, 64);
			end
			drain();
		end
		calm = 1'b0;

		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire

>>> files.f
sv/md5wm_pkg.sv
sv/md5wm_ram.sv
sv/md5_block_watermark_auth.sv
verif/tb_md5_block_watermark_auth.sv
